// ===== src/drp_pkg.sv =====
// shared constants, types and the power-of-ten table for the decimal
// scaled reciprocal unit; no dependencies
package drp_pkg;

	localparam int unsigned MAX_DIGITS = 9;
	localparam int unsigned DIV_W      = 32;
	localparam int unsigned VAL_W      = 30;
	localparam int unsigned PREC_W     = 4;
	localparam int unsigned PROD_W     = DIV_W + VAL_W;
	localparam int unsigned CNT_W      = 4;

	localparam logic [PREC_W-1:0] PREC_RESET = PREC_W'(4);
	localparam logic [PREC_W-1:0] PREC_MAX   = PREC_W'(MAX_DIGITS);
	// last trial index within one digit (ten trials at most)
	localparam logic [CNT_W-1:0]  K_LAST     = CNT_W'(9);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MUL,
		ST_CMP,
		ST_DONE
	} state_t;

	// ten to the power e, for e up to MAX_DIGITS
	function automatic logic [VAL_W-1:0] pow_ten(input logic [PREC_W-1:0] e);
		logic [VAL_W-1:0] v;
		case (e)
			4'd0:    v = VAL_W'(1);
			4'd1:    v = VAL_W'(10);
			4'd2:    v = VAL_W'(100);
			4'd3:    v = VAL_W'(1000);
			4'd4:    v = VAL_W'(10000);
			4'd5:    v = VAL_W'(100000);
			4'd6:    v = VAL_W'(1000000);
			4'd7:    v = VAL_W'(10000000);
			4'd8:    v = VAL_W'(100000000);
			4'd9:    v = VAL_W'(1000000000);
			default: v = VAL_W'(1);
		endcase
		return v;
	endfunction

endpackage

// ===== src/decimal_scaled_reciprocal_unit.sv =====
// top level of the decimal scaled reciprocal unit: sequencer, trial value
// registers and output register; depends on drp_pkg and drp_mulcmp
//
// channel   dir  handshake            payload
// in        in   in_valid/in_ready    divisor[31:0]
// out       out  out_valid/out_ready  reciprocal[29:0]
// cfg       in   cfg_we               cfg_wdata[3:0] (precision digits)
//
// one item at a time: ST_IDLE accepts it, then ST_MUL (multiply) and ST_CMP
// (compare) run once per trial on the shared multiplier, then ST_DONE loads
// the output register. each digit runs trials until its first failing one,
// capped at ten, so an item with precision p has between p and 10*p trials;
// at zero precision there are no trials and it goes straight to ST_DONE.
// reset clears the sequencer, output valid and sets precision to 4.
// a beat waiting on out does not block accepting the next input beat, but
// that item then holds in its final cycle until the waiting beat is taken.
module decimal_scaled_reciprocal_unit (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [drp_pkg::PREC_W-1:0]   cfg_wdata,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [drp_pkg::DIV_W-1:0]    divisor,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [drp_pkg::VAL_W-1:0]    reciprocal
);

	drp_pkg::state_t state_q, state_d;

	logic [drp_pkg::PREC_W-1:0] prec_q;
	logic [drp_pkg::PREC_W-1:0] p_sat;
	logic [drp_pkg::DIV_W-1:0]  x_q;
	logic [drp_pkg::VAL_W-1:0]  bound_q;
	logic [drp_pkg::VAL_W-1:0]  y_q;
	logic [drp_pkg::VAL_W-1:0]  trial_q;
	logic                       borrow_q;
	logic [drp_pkg::PREC_W-1:0] e_q;
	logic [drp_pkg::CNT_W-1:0]  k_q;
	logic                       out_valid_q;
	logic [drp_pkg::VAL_W-1:0]  reciprocal_q;

	logic                       accept;
	logic                       mul_en;
	logic                       cmp_en;
	logic                       finish;
	logic                       below;
	logic                       fail;
	logic                       digit_end;
	logic [drp_pkg::VAL_W-1:0]  y_new;
	logic [drp_pkg::VAL_W-1:0]  step_sel;
	logic [drp_pkg::VAL_W:0]    sub;
	logic [drp_pkg::VAL_W:0]    sub_init;

	// precision register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prec_q <= drp_pkg::PREC_RESET;
		end else if (cfg_we) begin
			prec_q <= cfg_wdata;
		end
	end

	assign p_sat = (prec_q > drp_pkg::PREC_MAX) ? drp_pkg::PREC_MAX : prec_q;

	// shared multiply-compare unit
	drp_mulcmp u_mulcmp (
		.clk     (clk),
		.en      (mul_en),
		.trial   (trial_q),
		.divisor (x_q),
		.bound   (bound_q),
		.below   (below)
	);

	// trial outcome and next trial value
	assign fail      = borrow_q || below;
	assign digit_end = fail || (k_q == drp_pkg::K_LAST);
	assign y_new     = fail ? y_q : trial_q;
	assign step_sel  = digit_end ? drp_pkg::pow_ten(e_q - drp_pkg::PREC_W'(1))
	                             : drp_pkg::pow_ten(e_q);
	assign sub       = {1'b0, y_new} - {1'b0, step_sel};
	assign sub_init  = {1'b0, drp_pkg::pow_ten(p_sat)}
	                 - {1'b0, drp_pkg::pow_ten(p_sat - drp_pkg::PREC_W'(1))};

	// sequencer next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			drp_pkg::ST_IDLE: begin
				if (in_valid) begin
					state_d = (p_sat == '0) ? drp_pkg::ST_DONE : drp_pkg::ST_MUL;
				end
			end
			drp_pkg::ST_MUL: state_d = drp_pkg::ST_CMP;
			drp_pkg::ST_CMP: begin
				state_d = (digit_end && (e_q == '0)) ? drp_pkg::ST_DONE : drp_pkg::ST_MUL;
			end
			drp_pkg::ST_DONE: begin
				if (!out_valid_q || out_ready) begin
					state_d = drp_pkg::ST_IDLE;
				end
			end
			default: state_d = drp_pkg::ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		in_ready = (state_q == drp_pkg::ST_IDLE);
		mul_en   = (state_q == drp_pkg::ST_MUL);
		cmp_en   = (state_q == drp_pkg::ST_CMP);
		finish   = (state_q == drp_pkg::ST_DONE) && (!out_valid_q || out_ready);
	end

	assign accept = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= drp_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// digit and trial counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			e_q <= '0;
			k_q <= '0;
		end else if (accept) begin
			e_q <= p_sat - drp_pkg::PREC_W'(1);
			k_q <= '0;
		end else if (cmp_en) begin
			if (digit_end) begin
				e_q <= e_q - drp_pkg::PREC_W'(1);
				k_q <= '0;
			end else begin
				k_q <= k_q + drp_pkg::CNT_W'(1);
			end
		end
	end

	// trial datapath
	always_ff @(posedge clk) begin
		if (accept) begin
			x_q      <= divisor;
			bound_q  <= drp_pkg::pow_ten(p_sat);
			y_q      <= drp_pkg::pow_ten(p_sat);
			trial_q  <= sub_init[drp_pkg::VAL_W-1:0];
			borrow_q <= 1'b0;
		end else if (cmp_en) begin
			y_q      <= y_new;
			trial_q  <= sub[drp_pkg::VAL_W-1:0];
			borrow_q <= sub[drp_pkg::VAL_W];
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (finish) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (finish) begin
			reciprocal_q <= y_q - drp_pkg::VAL_W'(1);
		end
	end

	assign out_valid  = out_valid_q;
	assign reciprocal = reciprocal_q;

	// an accepted beat starts trials, or finishes at once for zero precision
	a_start: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == drp_pkg::ST_MUL) || (state_q == drp_pkg::ST_DONE))
		else $error("sequencer did not start after accept");

	// the kept trial value never drops to zero in the compare and done states
	a_y_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == drp_pkg::ST_CMP) || (state_q == drp_pkg::ST_DONE) |-> y_q != '0)
		else $error("trial value reached zero");

	// at most ten trials per digit
	a_k_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == drp_pkg::ST_CMP) |-> k_q <= drp_pkg::K_LAST)
		else $error("trial counter out of range");

	// a finished result never exceeds nine nines
	a_out_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> reciprocal_q <= drp_pkg::VAL_W'(999999999))
		else $error("reciprocal out of range");

endmodule

// ===== src/drp_mulcmp.sv =====
// shared multiply-compare unit: registered exact product of trial and divisor,
// compared against the scale bound; depends on drp_pkg
module drp_mulcmp (
	input  logic                        clk,
	input  logic                        en,
	input  logic [drp_pkg::VAL_W-1:0]   trial,
	input  logic [drp_pkg::DIV_W-1:0]   divisor,
	input  logic [drp_pkg::VAL_W-1:0]   bound,
	output logic                        below
);

	logic [drp_pkg::PROD_W-1:0] prod;
	logic [drp_pkg::PROD_W-1:0] product_q;

	// exact wide product, no wrap
	assign prod = drp_pkg::PROD_W'(trial) * drp_pkg::PROD_W'(divisor);

	always_ff @(posedge clk) begin
		if (en) begin
			product_q <= prod;
		end
	end

	// product falls short of ten to the precision
	assign below = product_q < drp_pkg::PROD_W'(bound);

endmodule
